[src/battery_level_averaging_monitor_unit_macros.svh]
// assertion macros used by the battery monitor back end
`ifndef BATTERY_LEVEL_AVERAGING_MONITOR_UNIT_MACROS_SVH
`define BATTERY_LEVEL_AVERAGING_MONITOR_UNIT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BLAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define BLAM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[src/blam_pkg.sv]
// package with types, constants and widths of the battery monitor
package blam_pkg;

  localparam int HISTORY_DEPTH = 8;
  localparam int ADC_BITS      = 12;

  localparam int MV_W     = 16;
  localparam int SLOT_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SS_W     = ADC_BITS + 8;
  localparam int PROD_W   = ADC_BITS + 7;
  localparam int HSUM_W   = $clog2(HISTORY_DEPTH * 65535 + 1);
  localparam int DIV_W0   = (SS_W > PROD_W) ? SS_W : PROD_W;
  localparam int DIV_W    = (DIV_W0 > HSUM_W) ? DIV_W0 : HSUM_W;
  localparam int DVS_W0   = $clog2(HISTORY_DEPTH + 1);
  localparam int DVS_W    = (DVS_W0 > 10) ? DVS_W0 : 10;
  localparam int DCNT_W   = $clog2(DIV_W + 1);

  localparam logic [MV_W-1:0] RESET_MV = 16'd3510;
  localparam logic [MV_W-1:0] MV_MAX   = 16'hFFFF;
  localparam int              MV_SCALE = 100;

  // configuration reset values
  localparam logic [7:0]  SPR_RESET     = 8'd4;
  localparam logic [9:0]  DIVIDER_RESET = 10'd25;
  localparam logic [15:0] LIMIT_RESET   = 16'd3500;

  // configuration register indexes
  localparam logic [1:0] CFG_SAMPLES = 2'd0;
  localparam logic [1:0] CFG_DIVIDER = 2'd1;
  localparam logic [1:0] CFG_LIMIT   = 2'd2;

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FILL   = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [11:0] raw_sample;
    logic [15:0] fill_value;
  } item_t;

  typedef struct packed {
    logic [15:0] mean_mv;
    logic [15:0] reading_mv;
    logic        drained;
    logic [5:0]  next_slot;
  } result_t;

  typedef struct packed {
    logic [7:0]  samples_per_reading;
    logic [9:0]  divider_ratio;
    logic [15:0] limit_mv;
  } cfg_t;

  // command passed from front to back
  typedef struct packed {
    logic            kind;
    logic [MV_W-1:0] fill_value;
    logic [SS_W-1:0] sample_sum;
    logic [7:0]      sample_count;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

[src/blam_front.sv]
// front end: accepts requests and collects samples into reading commands
module blam_front (
  input  logic             clk,
  input  logic             rst,
  input  blam_pkg::cfg_t   cfg,
  input  logic             push,
  input  blam_pkg::item_t  item,
  input  logic             queue_full,
  output logic             cmd_push,
  output blam_pkg::cmd_t   cmd
);

  logic [blam_pkg::SS_W-1:0]     sample_sum;
  logic [7:0]                    sample_count;
  logic [blam_pkg::SS_W-1:0]     sample_sum_next;
  logic [7:0]                    sample_count_next;
  logic [15:0]                   raw_ext;
  logic [blam_pkg::ADC_BITS-1:0] raw;
  logic [7:0]                    need;
  logic                          accept;
  logic                          complete;

  assign accept  = push && !queue_full;
  assign raw_ext = 16'(item.raw_sample);
  assign raw     = raw_ext[blam_pkg::ADC_BITS-1:0];
  assign need    = (cfg.samples_per_reading == 8'd0) ? 8'd1 : cfg.samples_per_reading;

  // running sums with this sample added
  assign sample_sum_next   = sample_sum + blam_pkg::SS_W'(raw);
  assign sample_count_next = sample_count + 8'd1;
  assign complete = (sample_count_next != 8'd0) && (sample_count_next >= need);

  // command toward the back end
  always_comb begin
    cmd.kind         = item.req_type;
    cmd.fill_value   = item.fill_value;
    cmd.sample_sum   = sample_sum_next;
    cmd.sample_count = sample_count_next;
    cmd_push         = accept && ((item.req_type == blam_pkg::REQ_FILL) || complete);
  end

  // partial sample sum
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (item.req_type == blam_pkg::REQ_FILL || complete) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sample_sum_next;
        sample_count <= sample_count_next;
      end
    end
  end

endmodule

[src/blam_fifo.sv]
// two-entry command queue between front and back end
module blam_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  blam_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output logic           full,
  output logic           not_empty,
  output blam_pkg::cmd_t rd_data
);

  blam_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_data   = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/blam_div.sv]
// restoring divider, one quotient bit per cycle
module blam_div (
  input  logic               clk,
  input  logic               rst,
  input  blam_pkg::div_req_t req,
  output blam_pkg::div_rsp_t rsp
);

  logic                        busy;
  logic                        done;
  logic [blam_pkg::DCNT_W-1:0] cnt;
  logic [blam_pkg::DVS_W-1:0]  rem;
  logic [blam_pkg::DVS_W-1:0]  dvs;
  logic [blam_pkg::DIV_W-1:0]  quo;
  logic [blam_pkg::DVS_W:0]    trial;
  logic                        fits;

  // trial subtraction of the divisor
  assign trial = {rem, quo[blam_pkg::DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= blam_pkg::DVS_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[blam_pkg::DVS_W-1:0];
      end
      quo <= {quo[blam_pkg::DIV_W-2:0], fits};
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == blam_pkg::DCNT_W'(blam_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/blam_back.sv]
// back end: scales readings, updates the history ring, builds results
`include "battery_level_averaging_monitor_unit_macros.svh"

module blam_back (
  input  logic               clk,
  input  logic               rst,
  input  blam_pkg::cfg_t     cfg,
  input  logic               cmd_valid,
  input  blam_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  output blam_pkg::div_req_t div_req,
  input  blam_pkg::div_rsp_t div_rsp,
  input  logic               pop,
  output logic               empty,
  output blam_pkg::result_t  result
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b000_0001,
    S_DIV1  = 7'b000_0010,
    S_SCALE = 7'b000_0100,
    S_DIV2  = 7'b000_1000,
    S_UPD   = 7'b001_0000,
    S_MEAN  = 7'b010_0000,
    S_EMIT  = 7'b100_0000
  } state_t;

  state_t                          state;
  logic [blam_pkg::MV_W-1:0]       hist_mem [blam_pkg::HISTORY_DEPTH];
  logic [blam_pkg::HISTORY_DEPTH-1:0] slot_valid;
  logic [blam_pkg::MV_W-1:0]       base_mv;
  logic [blam_pkg::MV_W-1:0]       rd_data;
  logic                            rd_valid;
  logic [blam_pkg::SLOT_W-1:0]     slot;
  logic [blam_pkg::HSUM_W-1:0]     hist_sum;
  logic [blam_pkg::PROD_W-1:0]     prod;
  logic [blam_pkg::MV_W-1:0]       reading;
  logic [blam_pkg::MV_W-1:0]       mean;
  logic [blam_pkg::MV_W-1:0]       old_mv;
  logic [blam_pkg::MV_W-1:0]       scaled_mv;
  logic [blam_pkg::HSUM_W-1:0]     hist_sum_next;
  logic                            res_valid;
  logic                            res_load;
  logic                            is_fill;

  assign is_fill  = (cmd.kind == blam_pkg::REQ_FILL);
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign res_load = (state == S_EMIT) && (!res_valid || pop);
  assign empty    = !res_valid;

  // ring update arithmetic
  assign old_mv        = rd_valid ? rd_data : base_mv;
  assign hist_sum_next = hist_sum - blam_pkg::HSUM_W'(old_mv) + blam_pkg::HSUM_W'(reading);

  // saturated scaled reading from the divider
  assign scaled_mv = (div_rsp.quotient[blam_pkg::DIV_W-1:blam_pkg::MV_W] != '0)
                     ? blam_pkg::MV_MAX : div_rsp.quotient[blam_pkg::MV_W-1:0];

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = blam_pkg::DIV_W'(cmd.sample_sum);
    div_req.divisor  = blam_pkg::DVS_W'(cmd.sample_count);
    case (state)
      S_IDLE: begin
        div_req.start = cmd_valid && !is_fill;
      end
      S_SCALE: begin
        div_req.start    = (cfg.divider_ratio != 10'd0);
        div_req.dividend = blam_pkg::DIV_W'(prod);
        div_req.divisor  = blam_pkg::DVS_W'(cfg.divider_ratio);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // history memory, written once per reading and read at the slot to replace
  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      hist_mem[slot] <= reading;
    end
    if (cmd_pop) begin
      rd_data <= hist_mem[slot];
    end
  end

  // sequencer and ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      base_mv    <= blam_pkg::RESET_MV;
      slot       <= '0;
      hist_sum   <= blam_pkg::HSUM_W'(blam_pkg::HISTORY_DEPTH)
                    * blam_pkg::HSUM_W'(blam_pkg::RESET_MV);
      rd_valid   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            rd_valid <= slot_valid[slot];
            if (is_fill) begin
              slot_valid <= '0;
              base_mv    <= cmd.fill_value;
              slot       <= '0;
              hist_sum   <= blam_pkg::HSUM_W'(blam_pkg::HISTORY_DEPTH)
                            * blam_pkg::HSUM_W'(cmd.fill_value);
              reading    <= cmd.fill_value;
              state      <= S_MEAN;
            end else begin
              state <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            prod  <= blam_pkg::PROD_W'(div_rsp.quotient[blam_pkg::ADC_BITS-1:0])
                     * blam_pkg::PROD_W'(blam_pkg::MV_SCALE);
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (cfg.divider_ratio == 10'd0) begin
            reading <= blam_pkg::MV_MAX;
            state   <= S_UPD;
          end else begin
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            reading <= scaled_mv;
            state   <= S_UPD;
          end
        end
        S_UPD: begin
          hist_sum         <= hist_sum_next;
          slot_valid[slot] <= 1'b1;
          if (slot == blam_pkg::SLOT_W'(blam_pkg::HISTORY_DEPTH - 1)) begin
            slot <= '0;
          end else begin
            slot <= slot + 1'b1;
          end
          state <= S_MEAN;
        end
        // ring mean, depth is a power of two
        S_MEAN: begin
          mean  <= blam_pkg::MV_W'(hist_sum / blam_pkg::HSUM_W'(blam_pkg::HISTORY_DEPTH));
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register toward the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.mean_mv    <= mean;
      result.reading_mv <= reading;
      result.drained    <= (mean < cfg.limit_mv);
      result.next_slot  <= 6'(slot);
    end
  end

  `BLAM_ASSERT(a_res_no_overwrite, res_load |-> (!res_valid || pop), "result overwritten")
  `BLAM_ASSERT(a_div_idle_start, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
  `BLAM_ASSERT(a_fill_resets_slot, (cmd_pop && is_fill) |=> (slot == '0), "fill left slot index")
  `BLAM_ASSERT_NEVER(a_pop_without_cmd, cmd_pop && !cmd_valid, "command taken from empty queue")

endmodule

[src/battery_level_averaging_monitor_unit.sv]
// top level of the battery level averaging monitor
//
//  channel   direction  handshake          payload
//  item      in         push / full        item_t: req_type, raw_sample, fill_value
//  result    out        empty / pop        result_t: mean_mv, reading_mv, drained, next_slot
//  config    in         cfg_we             cfg_index, cfg_data
//
//  a sample that does not close a reading only adds to the partial sum in the front end.
//  a closing sample runs the one-bit-per-cycle divider twice, for the mean and the scaling;
//  a zero divider skips the scaling run, and a fill skips both runs.
//  a two-entry command queue lets the front keep taking samples while the back is busy.
//  full rises only when that queue holds two commands; a held result stalls the back end.
//  rst is synchronous; the history ring is cleared by valid bits, with no clearing pass.
module battery_level_averaging_monitor_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  blam_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output blam_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  blam_pkg::cfg_t     cfg;
  blam_pkg::cmd_t     front_cmd;
  blam_pkg::cmd_t     queue_cmd;
  blam_pkg::div_req_t div_req;
  blam_pkg::div_rsp_t div_rsp;
  logic               front_push;
  logic               queue_valid;
  logic               queue_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples_per_reading <= blam_pkg::SPR_RESET;
      cfg.divider_ratio       <= blam_pkg::DIVIDER_RESET;
      cfg.limit_mv            <= blam_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        blam_pkg::CFG_SAMPLES: cfg.samples_per_reading <= cfg_data[7:0];
        blam_pkg::CFG_DIVIDER: cfg.divider_ratio       <= cfg_data[9:0];
        blam_pkg::CFG_LIMIT:   cfg.limit_mv            <= cfg_data;
        default:               cfg                     <= cfg;
      endcase
    end
  end

  blam_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .item       (item),
    .queue_full (full),
    .cmd_push   (front_push),
    .cmd        (front_cmd)
  );

  blam_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (front_push),
    .wr_data   (front_cmd),
    .rd_en     (queue_pop),
    .full      (full),
    .not_empty (queue_valid),
    .rd_data   (queue_cmd)
  );

  blam_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  blam_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (queue_valid),
    .cmd       (queue_cmd),
    .cmd_pop   (queue_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

[tb/tb_battery_level_averaging_monitor_unit.sv]
// self-checking testbench for the battery level averaging monitor unit
module tb_battery_level_averaging_monitor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PRINT_LIMIT   = 50;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              push       = 1'b0;
  logic              full;
  blam_pkg::item_t   request_in = '0;
  logic              empty;
  logic              pop        = 1'b0;
  blam_pkg::result_t report_out;
  logic              cfg_we     = 1'b0;
  logic [1:0]        cfg_index  = blam_pkg::CFG_SAMPLES;
  logic [15:0]       cfg_data   = '0;

  // idling odds in percent, shared by sender and receiver
  int idle_pct    = 20;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int stall_left  = 0;
  int error_count = 0;
  int cycle_count = 0;

  // monitor state as the block should hold it
  logic [15:0]       ring_mv [blam_pkg::HISTORY_DEPTH];
  int unsigned       ring_sum;
  int unsigned       ring_slot;
  int unsigned       partial_sum;
  logic [7:0]        partial_count;
  logic [7:0]        spr_reg;
  logic [9:0]        divider_reg;
  logic [15:0]       limit_reg;
  blam_pkg::result_t awaited_reports [$];

  battery_level_averaging_monitor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (request_in),
    .empty     (empty),
    .pop       (pop),
    .result    (report_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ring fill: every slot, index and partial sum
  function automatic void fill_ring_model(input logic [15:0] mv);
    for (int i = 0; i < blam_pkg::HISTORY_DEPTH; i++) ring_mv[i] = mv;
    ring_sum      = blam_pkg::HISTORY_DEPTH * mv;
    ring_slot     = 0;
    partial_sum   = 0;
    partial_count = '0;
  endfunction

  // raw mean to millivolts, truncated and saturated
  function automatic logic [15:0] scale_to_mv(input int unsigned mean, input logic [9:0] div);
    int unsigned mv;
    if (div == '0) return blam_pkg::MV_MAX;
    mv = (mean * blam_pkg::MV_SCALE) / div;
    return (mv > 65535) ? blam_pkg::MV_MAX : 16'(mv);
  endfunction

  function automatic logic [15:0] ring_mean();
    return 16'(ring_sum / blam_pkg::HISTORY_DEPTH);
  endfunction

  function automatic void post_report(input logic [15:0] reading);
    blam_pkg::result_t r;
    r.mean_mv    = ring_mean();
    r.reading_mv = reading;
    r.drained    = (r.mean_mv < limit_reg);
    r.next_slot  = 6'(ring_slot);
    awaited_reports.push_back(r);
  endfunction

  // expected report for one accepted request, if it closes a reading or fills
  function automatic void predict_report(input blam_pkg::item_t req);
    int unsigned need;
    int unsigned mean;
    int unsigned pos;
    logic [15:0] mv;
    if (req.req_type == blam_pkg::REQ_FILL) begin
      fill_ring_model(req.fill_value);
      post_report(req.fill_value);
      return;
    end
    partial_sum   = partial_sum + req.raw_sample;
    partial_count = partial_count + 8'd1;
    need = (spr_reg == '0) ? 1 : spr_reg;
    if (partial_count == '0 || partial_count < need) return;
    mean          = partial_sum / partial_count;
    partial_sum   = 0;
    partial_count = '0;
    mv  = scale_to_mv(mean, divider_reg);
    pos = ring_slot % blam_pkg::HISTORY_DEPTH;
    ring_sum     = ring_sum - ring_mv[pos[blam_pkg::SLOT_W-1:0]] + mv;
    ring_mv[pos[blam_pkg::SLOT_W-1:0]] = mv;
    ring_slot    = (pos + 1) % blam_pkg::HISTORY_DEPTH;
    post_report(mv);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch in %s: got %0d, expected %0d (cycle %0d)", what, got, want,
               cycle_count);
  endtask

  // result check and receiver stalls
  always @(posedge clk) begin
    blam_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (awaited_reports.size() == 0) begin
        report_mismatch("unrequested report, reading_mv", int'(report_out.reading_mv), 0);
      end else begin
        want = awaited_reports.pop_front();
        if (report_out.mean_mv !== want.mean_mv)
          report_mismatch("mean_mv", int'(report_out.mean_mv), int'(want.mean_mv));
        if (report_out.reading_mv !== want.reading_mv)
          report_mismatch("reading_mv", int'(report_out.reading_mv), int'(want.reading_mv));
        if (report_out.drained !== want.drained)
          report_mismatch("drained", int'(report_out.drained), int'(want.drained));
        if (report_out.next_slot !== want.next_slot)
          report_mismatch("next_slot", int'(report_out.next_slot), int'(want.next_slot));
      end
    end
    if (hold_ticket != hold_served) begin
      hold_served = hold_ticket;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 8);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // one request, with an optional gap before it
  task automatic send_request(input logic kind, input logic [11:0] raw,
                              input logic [15:0] fillv);
    blam_pkg::item_t req;
    req.req_type   = kind;
    req.raw_sample = raw;
    req.fill_value = fillv;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    push       <= 1'b1;
    request_in <= req;
    do @(posedge clk); while (full);
    predict_report(req);
  endtask

  task automatic send_sample(input logic [11:0] raw);
    send_request(blam_pkg::REQ_SAMPLE, raw, 16'($urandom));
  endtask

  task automatic send_fill(input logic [15:0] mv);
    send_request(blam_pkg::REQ_FILL, 12'($urandom), mv);
  endtask

  // stop sending, wait for every report, then let the front end settle
  task automatic wait_drained();
    push <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [1:0] index, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      blam_pkg::CFG_SAMPLES: spr_reg     = value[7:0];
      blam_pkg::CFG_DIVIDER: divider_reg = value[9:0];
      blam_pkg::CFG_LIMIT:   limit_reg   = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // all three registers, junk in the unused upper bits
  task automatic set_monitor(input logic [7:0] spr, input logic [9:0] div,
                             input logic [15:0] lim);
    wait_drained();
    write_config(blam_pkg::CFG_SAMPLES, {8'($urandom), spr});
    write_config(blam_pkg::CFG_DIVIDER, {6'($urandom), div});
    write_config(blam_pkg::CFG_LIMIT, lim);
  endtask

  // readings with the reset settings
  task automatic test_reset_defaults();
    repeat (4) send_sample(12'd875);
    repeat (4) send_sample(12'd4095);
  endtask

  // fills around the limit, fill discarding a partial reading, largest ring sum
  task automatic test_fill_history();
    send_fill(16'd0);
    send_fill(16'd3500);
    send_fill(16'd3499);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_fill(16'hFFFF);
    repeat (4) send_sample(12'd0);
  endtask

  // zero divider, saturation edge, widest divider, zero count acting as one
  task automatic test_divider_extremes();
    set_monitor(8'd0, 10'd0, 16'hFFFF);
    send_sample(12'($urandom));
    set_monitor(8'd1, 10'd1, 16'd0);
    send_sample(12'd655);
    send_sample(12'd656);
    send_sample(12'd0);
    set_monitor(8'd1, 10'd1023, 16'($urandom));
    send_sample(12'd4095);
  endtask

  // count lowered while a reading is partly taken
  task automatic test_count_lowered();
    set_monitor(8'd8, 10'd25, 16'd3500);
    repeat (3) send_sample(12'($urandom));
    set_monitor(8'd2, 10'd25, 16'd3500);
    send_sample(12'($urandom));
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_result_backpressure();
    set_monitor(8'd1, 10'd25, 16'($urandom));
    idle_pct    <= 0;
    hold_ticket <= hold_ticket + 1;
    repeat (24) send_sample(12'($urandom));
  endtask

  // random phases, each with its own settings
  task automatic test_random_traffic(input int phases, input bit quiet, input bit deep);
    int len;
    int base;
    int near;
    int tmp;
    int pick;
    logic [7:0]  spr;
    logic [9:0]  div;
    logic [15:0] lim;
    logic [11:0] raw;
    for (int p = 0; p < phases; p++) begin
      pick = $urandom_range(0, 18);
      if (deep && p == 1) spr = 8'd255;
      else if (pick == 0) spr = 8'd0;
      else if (pick == 1) spr = 8'd1;
      else if (pick < 5)  spr = 8'($urandom_range(8, 40));
      else                spr = 8'($urandom_range(2, 6));
      pick = $urandom_range(0, 9);
      if (pick == 0)      div = 10'd0;
      else if (pick == 1) div = 10'd1;
      else if (pick == 2) div = 10'd1023;
      else if (pick == 3) div = 10'($urandom_range(1, 1023));
      else                div = 10'($urandom_range(20, 40));
      base = $urandom_range(0, 4095);
      near = int'(scale_to_mv(base, div));
      pick = $urandom_range(0, 7);
      if (pick == 0)      lim = 16'd0;
      else if (pick == 1) lim = 16'hFFFF;
      else if (pick == 2) lim = 16'($urandom);
      else begin
        tmp = near + int'($urandom_range(0, 64)) - 32;
        lim = 16'((tmp < 0) ? 0 : (tmp > 65535) ? 65535 : tmp);
      end
      set_monitor(spr, div, lim);
      idle_pct <= quiet ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40));
      len = (spr == 8'd255) ? 520 : $urandom_range(30, 70);
      for (int i = 0; i < len; i++) begin
        // sender pause until every report is back
        if (p % 4 == 2 && i == len / 2) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          send_fill(($urandom_range(0, 1) == 0) ? 16'($urandom) : lim);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 45) begin
            tmp = base + int'($urandom_range(0, 80)) - 40;
            raw = 12'((tmp < 0) ? 0 : (tmp > 4095) ? 4095 : tmp);
          end else if (pick < 55) begin
            raw = 12'd0;
          end else if (pick < 65) begin
            raw = 12'd4095;
          end else begin
            raw = 12'($urandom);
          end
          send_sample(raw);
        end
      end
    end
  endtask

  // test sequence
  initial begin
    spr_reg     = blam_pkg::SPR_RESET;
    divider_reg = blam_pkg::DIVIDER_RESET;
    limit_reg   = blam_pkg::LIMIT_RESET;
    fill_ring_model(blam_pkg::RESET_MV);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_fill_history();
    test_divider_extremes();
    test_count_lowered();
    test_result_backpressure();
    test_random_traffic(22, 1'b0, 1'b1);
    test_random_traffic(4, 1'b1, 1'b0);
    wait_drained();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
